FILE: rtl/tsq_pkg.sv
package tsq_pkg;

    localparam int THREAD_SLOTS_DEF = 64;
    localparam int AMOUNT_BITS_DEF  = 16;

    localparam int CMD_W      = 3;
    localparam int AMT_IN_W   = 16;
    localparam int PID_OUT_W  = 6;
    localparam int WOKE_OUT_W = 7;
    localparam int REARM_W    = 8;
    localparam logic [REARM_W-1:0] REARM_RESET = 8'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE     = 3'd0,
        CMD_EXIT       = 3'd1,
        CMD_YIELD      = 3'd2,
        CMD_BLOCK_READ = 3'd3,
        CMD_SLEEP      = 3'd4,
        CMD_WAKE       = 3'd5,
        CMD_TICK       = 3'd6,
        CMD_REAP       = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FREE      = 3'd0,
        ST_READY     = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_PENDING   = 3'd3,
        ST_WAIT_READ = 3'd4,
        ST_SLEEPING  = 3'd5,
        ST_DEAD      = 3'd6
    } slot_st_t;

    typedef enum logic [1:0] {
        PB_NONE  = 2'd0,
        PB_READ  = 2'd1,
        PB_SLEEP = 2'd2
    } pblock_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [AMT_IN_W-1:0] amount;
    } tsq_in_t;

    typedef struct packed {
        logic [PID_OUT_W-1:0]  current_pid;
        logic                  switched;
        logic [PID_OUT_W-1:0]  new_pid;
        logic                  create_ok;
        logic [AMT_IN_W-1:0]   read_head_size;
        logic                  read_queue_empty;
        logic [REARM_W-1:0]    rearm_ticks;
        logic [WOKE_OUT_W-1:0] woke_count;
    } tsq_out_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_BLK_RD,
        CS_BLK_CHK,
        CS_EXIT,
        CS_SW_POP_RD,
        CS_SW_POP,
        CS_SW_CUR_RD,
        CS_SW_CUR,
        CS_WAKE_RD,
        CS_WAKE,
        CS_SCAN_INIT,
        CS_SCAN,
        CS_HEAD_RD,
        CS_HEAD_AMT,
        CS_LOAD_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_BLK_CHK,
        OP_EXIT,
        OP_SW_POP,
        OP_SW_CUR,
        OP_WAKE,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_HEAD_AMT,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic run_empty;
        logic read_empty;
        logic scan_done;
        logic create_found;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/tsq_if.sv
interface tsq_in_if import tsq_pkg::*; ();
    logic    valid;
    logic    ready;
    tsq_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tsq_out_if import tsq_pkg::*; ();
    logic     valid;
    logic     ready;
    tsq_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tsq_cfg_if import tsq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REARM_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tsq_ctrl.sv
module tsq_ctrl import tsq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_DISPATCH;
                end
            end
            CS_DISPATCH:
            begin
                case (status.cmd)
                    CMD_CREATE, CMD_TICK, CMD_REAP: state_next = CS_SCAN_INIT;
                    CMD_EXIT:                       state_next = CS_EXIT;
                    CMD_YIELD:                      state_next = CS_SW_POP_RD;
                    CMD_BLOCK_READ, CMD_SLEEP:      state_next = CS_BLK_RD;
                    CMD_WAKE:                       state_next = CS_WAKE_RD;
                    default:                        state_next = CS_HEAD_RD;
                endcase
            end
            CS_BLK_RD:    state_next = CS_BLK_CHK;
            CS_BLK_CHK:   state_next = CS_SW_POP_RD;
            CS_EXIT:      state_next = CS_SW_POP_RD;
            CS_SW_POP_RD: state_next = status.run_empty ? CS_HEAD_RD : CS_SW_POP;
            CS_SW_POP:    state_next = CS_SW_CUR_RD;
            CS_SW_CUR_RD: state_next = CS_SW_CUR;
            CS_SW_CUR:    state_next = CS_HEAD_RD;
            CS_WAKE_RD:   state_next = status.read_empty ? CS_HEAD_RD : CS_WAKE;
            CS_WAKE:      state_next = CS_HEAD_RD;
            CS_SCAN_INIT: state_next = CS_SCAN;
            CS_SCAN:
            begin
                if (status.scan_done || status.create_found)
                begin
                    state_next = CS_HEAD_RD;
                end
            end
            CS_HEAD_RD:   state_next = CS_HEAD_AMT;
            CS_HEAD_AMT:  state_next = CS_LOAD_OUT;
            CS_LOAD_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:      state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        op       = OP_NONE;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? OP_ACCEPT : OP_NONE;
            end
            CS_BLK_CHK:   op = OP_BLK_CHK;
            CS_EXIT:      op = OP_EXIT;
            CS_SW_POP:    op = OP_SW_POP;
            CS_SW_CUR:    op = OP_SW_CUR;
            CS_WAKE:      op = OP_WAKE;
            CS_SCAN_INIT: op = OP_SCAN_INIT;
            CS_SCAN:      op = OP_SCAN;
            CS_HEAD_AMT:  op = OP_HEAD_AMT;
            // While the result register is still held, keep reading the head amount.
            CS_LOAD_OUT:  op = status.out_free ? OP_LOAD_OUT : OP_HEAD_AMT;
            default:      op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/tsq_dp.sv
module tsq_dp import tsq_pkg::*; #(
    parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
    parameter int AMOUNT_BITS  = AMOUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_op_t             op,
    input  tsq_in_t            in_item,
    input  logic               cfg_we,
    input  logic [REARM_W-1:0] cfg_data,
    output dp_status_t         status,
    output tsq_out_t           out_item,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int PW = $clog2(THREAD_SLOTS);
    localparam int CW = $clog2(THREAD_SLOTS + 1);
    localparam int AW = AMOUNT_BITS;
    localparam logic [CW:0]   N_EXT    = (CW + 1)'(THREAD_SLOTS);
    localparam logic [CW-1:0] N_CNT    = CW'(THREAD_SLOTS);
    localparam logic [PW-1:0] LAST_IDX = PW'(THREAD_SLOTS - 1);

    // Memories
    logic [2:0]    st_mem  [THREAD_SLOTS];
    logic [AW-1:0] amt_mem [THREAD_SLOTS];
    logic [PW-1:0] run_mem [THREAD_SLOTS];
    logic [PW-1:0] rdf_mem [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0] st_vld_reg;

    // Registered read data
    logic [2:0]    st_rd_reg;
    logic          st_rd_vld_reg;
    logic          st_rd_zero_reg;
    logic [AW-1:0] amt_rd_reg;
    logic [PW-1:0] run_rd_reg;
    logic [PW-1:0] rdf_rd_reg;

    // Control and working registers
    cmd_t               cmd_reg,        cmd_next;
    logic [AW-1:0]      amt_reg,        amt_next;
    logic [PW-1:0]      running_reg,    running_next;
    pblock_t            pb_reg,         pb_next;
    logic [PW-1:0]      run_head_reg,   run_head_next;
    logic [CW-1:0]      run_count_reg,  run_count_next;
    logic [PW-1:0]      rdf_head_reg,   rdf_head_next;
    logic [CW-1:0]      rdf_count_reg,  rdf_count_next;
    logic [PW-1:0]      nxt_reg,        nxt_next;
    logic [CW-1:0]      scan_idx_reg,   scan_idx_next;
    logic [PW-1:0]      chk_idx_reg,    chk_idx_next;
    logic               chk_vld_reg,    chk_vld_next;
    logic               switched_reg,   switched_next;
    logic [PW-1:0]      new_pid_reg,    new_pid_next;
    logic               create_ok_reg,  create_ok_next;
    logic               rearm_reg,      rearm_next;
    logic [CW-1:0]      woke_reg,       woke_next;
    logic [REARM_W-1:0] period_reg,     period_next;
    tsq_out_t           out_reg,        out_next;
    logic               out_valid_reg,  out_valid_next;

    // Memory port controls
    logic          st_we;
    logic [PW-1:0] st_waddr;
    slot_st_t      st_wdata;
    logic [PW-1:0] st_raddr;
    logic          amt_we;
    logic [PW-1:0] amt_waddr;
    logic [AW-1:0] amt_wdata;
    logic [PW-1:0] amt_raddr;
    logic          run_push;
    logic [PW-1:0] run_push_val;
    logic          run_pop;
    logic          rdf_push;
    logic          rdf_pop;
    logic [CW:0]   run_sum;
    logic [CW:0]   rdf_sum;
    logic [PW-1:0] run_tail;
    logic [PW-1:0] rdf_tail;
    logic [AW-1:0] amt_dec;
    slot_st_t      st_rdata;

    assign st_rdata = st_rd_vld_reg ? slot_st_t'(st_rd_reg)
                                    : (st_rd_zero_reg ? ST_RUNNING : ST_FREE);
    assign amt_dec  = (amt_rd_reg != '0) ? amt_rd_reg - 1'b1 : amt_rd_reg;

    always_comb
    begin
        run_sum  = (CW + 1)'(run_head_reg) + (CW + 1)'(run_count_reg);
        rdf_sum  = (CW + 1)'(rdf_head_reg) + (CW + 1)'(rdf_count_reg);
        run_tail = (run_sum >= N_EXT) ? PW'(run_sum - N_EXT) : PW'(run_sum);
        rdf_tail = (rdf_sum >= N_EXT) ? PW'(rdf_sum - N_EXT) : PW'(rdf_sum);
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        amt_next       = amt_reg;
        running_next   = running_reg;
        pb_next        = pb_reg;
        nxt_next       = nxt_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_vld_next   = chk_vld_reg;
        switched_next  = switched_reg;
        new_pid_next   = new_pid_reg;
        create_ok_next = create_ok_reg;
        rearm_next     = rearm_reg;
        woke_next      = woke_reg;
        period_next    = cfg_we ? cfg_data : period_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        st_we        = 1'b0;
        st_waddr     = running_reg;
        st_wdata     = ST_FREE;
        st_raddr     = running_reg;
        amt_we       = 1'b0;
        amt_waddr    = running_reg;
        amt_wdata    = amt_reg;
        amt_raddr    = PW'(scan_idx_reg);
        run_push     = 1'b0;
        run_push_val = running_reg;
        run_pop      = 1'b0;
        rdf_push     = 1'b0;
        rdf_pop      = 1'b0;

        case (op)
            OP_ACCEPT:
            begin
                cmd_next       = cmd_t'(in_item.cmd);
                amt_next       = AW'(in_item.amount);
                switched_next  = 1'b0;
                new_pid_next   = '0;
                create_ok_next = 1'b0;
                rearm_next     = 1'b0;
                woke_next      = '0;
            end
            OP_BLK_CHK:
            begin
                if ((amt_reg != '0) && (st_rdata == ST_RUNNING))
                begin
                    st_we    = 1'b1;
                    st_wdata = ST_PENDING;
                    amt_we   = 1'b1;
                    pb_next  = (cmd_reg == CMD_BLOCK_READ) ? PB_READ : PB_SLEEP;
                end
            end
            OP_EXIT:
            begin
                st_we    = 1'b1;
                st_wdata = ST_DEAD;
                pb_next  = PB_NONE;
            end
            OP_SW_POP:
            begin
                nxt_next = run_rd_reg;
                run_pop  = 1'b1;
                st_we    = 1'b1;
                st_waddr = run_rd_reg;
                st_wdata = ST_RUNNING;
            end
            OP_SW_CUR:
            begin
                case (st_rdata)
                    ST_PENDING:
                    begin
                        st_we = 1'b1;
                        if (pb_reg == PB_READ)
                        begin
                            st_wdata = ST_WAIT_READ;
                            rdf_push = 1'b1;
                        end
                        else
                        begin
                            st_wdata   = ST_SLEEPING;
                            rearm_next = 1'b1;
                        end
                    end
                    ST_RUNNING:
                    begin
                        st_we    = 1'b1;
                        st_wdata = ST_READY;
                        run_push = 1'b1;
                    end
                    default:
                    begin
                        st_we = 1'b0;
                    end
                endcase
                pb_next       = PB_NONE;
                running_next  = nxt_reg;
                switched_next = 1'b1;
            end
            OP_WAKE:
            begin
                rdf_pop      = 1'b1;
                st_we        = 1'b1;
                st_waddr     = rdf_rd_reg;
                st_wdata     = ST_READY;
                run_push     = 1'b1;
                run_push_val = rdf_rd_reg;
                woke_next    = CW'(1);
            end
            OP_SCAN_INIT:
            begin
                scan_idx_next = (cmd_reg == CMD_CREATE) ? CW'(1) : '0;
                chk_vld_next  = 1'b0;
            end
            OP_SCAN:
            begin
                st_raddr = PW'(scan_idx_reg);
                if (scan_idx_reg != N_CNT)
                begin
                    chk_idx_next  = PW'(scan_idx_reg);
                    chk_vld_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    st_waddr     = chk_idx_reg;
                    amt_waddr    = chk_idx_reg;
                    run_push_val = chk_idx_reg;
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (!create_ok_reg && (st_rdata == ST_FREE))
                            begin
                                st_we          = 1'b1;
                                st_wdata       = ST_READY;
                                run_push       = 1'b1;
                                new_pid_next   = chk_idx_reg;
                                create_ok_next = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (st_rdata == ST_SLEEPING)
                            begin
                                amt_we    = 1'b1;
                                amt_wdata = amt_dec;
                                if (amt_dec == '0)
                                begin
                                    st_we     = 1'b1;
                                    st_wdata  = ST_READY;
                                    run_push  = 1'b1;
                                    woke_next = woke_reg + 1'b1;
                                end
                                else
                                begin
                                    rearm_next = 1'b1;
                                end
                            end
                        end
                        CMD_REAP:
                        begin
                            if (st_rdata == ST_DEAD)
                            begin
                                st_we    = 1'b1;
                                st_wdata = ST_FREE;
                            end
                        end
                        default:
                        begin
                            st_we = 1'b0;
                        end
                    endcase
                end
            end
            OP_HEAD_AMT:
            begin
                amt_raddr = rdf_rd_reg;
            end
            OP_LOAD_OUT:
            begin
                out_next.current_pid      = PID_OUT_W'(running_reg);
                out_next.switched         = switched_reg;
                out_next.new_pid          = PID_OUT_W'(new_pid_reg);
                out_next.create_ok        = create_ok_reg;
                out_next.read_head_size   = (rdf_count_reg != '0) ? AMT_IN_W'(amt_rd_reg) : '0;
                out_next.read_queue_empty = (rdf_count_reg == '0);
                out_next.rearm_ticks      = rearm_reg ? period_reg : '0;
                out_next.woke_count       = WOKE_OUT_W'(woke_reg);
                out_valid_next            = 1'b1;
            end
            default:
            begin
                st_we = 1'b0;
            end
        endcase

        run_push = run_push && (run_count_reg != N_CNT);
        rdf_push = rdf_push && (rdf_count_reg != N_CNT);

        run_head_next  = run_head_reg;
        run_count_next = run_count_reg;
        if (run_pop)
        begin
            run_head_next  = (run_head_reg == LAST_IDX) ? '0 : run_head_reg + 1'b1;
            run_count_next = run_count_next - 1'b1;
        end
        if (run_push)
        begin
            run_count_next = run_count_next + 1'b1;
        end

        rdf_head_next  = rdf_head_reg;
        rdf_count_next = rdf_count_reg;
        if (rdf_pop)
        begin
            rdf_head_next  = (rdf_head_reg == LAST_IDX) ? '0 : rdf_head_reg + 1'b1;
            rdf_count_next = rdf_count_next - 1'b1;
        end
        if (rdf_push)
        begin
            rdf_count_next = rdf_count_next + 1'b1;
        end
    end

    // Memories and their registered read ports
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rd_reg      <= st_mem[st_raddr];
        st_rd_vld_reg  <= st_vld_reg[st_raddr];
        st_rd_zero_reg <= (st_raddr == '0);
    end

    always_ff @(posedge clk)
    begin
        if (amt_we)
        begin
            amt_mem[amt_waddr] <= amt_wdata;
        end
        amt_rd_reg <= amt_mem[amt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (run_push)
        begin
            run_mem[run_tail] <= run_push_val;
        end
        run_rd_reg <= run_mem[run_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rdf_push)
        begin
            rdf_mem[rdf_tail] <= running_reg;
        end
        rdf_rd_reg <= rdf_mem[rdf_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
        end
        else if (st_we)
        begin
            st_vld_reg[st_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_CREATE;
            running_reg   <= '0;
            pb_reg        <= PB_NONE;
            run_head_reg  <= '0;
            run_count_reg <= '0;
            rdf_head_reg  <= '0;
            rdf_count_reg <= '0;
            scan_idx_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            create_ok_reg <= 1'b0;
            period_reg    <= REARM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_reg       <= cmd_next;
            running_reg   <= running_next;
            pb_reg        <= pb_next;
            run_head_reg  <= run_head_next;
            run_count_reg <= run_count_next;
            rdf_head_reg  <= rdf_head_next;
            rdf_count_reg <= rdf_count_next;
            scan_idx_reg  <= scan_idx_next;
            chk_vld_reg   <= chk_vld_next;
            create_ok_reg <= create_ok_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg      <= amt_next;
        nxt_reg      <= nxt_next;
        chk_idx_reg  <= chk_idx_next;
        switched_reg <= switched_next;
        new_pid_reg  <= new_pid_next;
        rearm_reg    <= rearm_next;
        woke_reg     <= woke_next;
        out_reg      <= out_next;
    end

    assign status.cmd          = cmd_reg;
    assign status.run_empty    = (run_count_reg == '0);
    assign status.read_empty   = (rdf_count_reg == '0);
    assign status.scan_done    = (scan_idx_reg == N_CNT) && !chk_vld_reg;
    assign status.create_found = create_ok_reg;
    assign status.out_free     = !out_valid_reg || out_ready;
    assign out_item            = out_reg;
    assign out_valid           = out_valid_reg;

    a_run_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg <= N_CNT)
        else $error("run queue count beyond slot count");

    a_rdf_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rdf_count_reg <= N_CNT)
        else $error("read queue count beyond slot count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_SW_POP |-> run_count_reg != '0)
        else $error("switch popped an empty run queue");

    a_wake_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_WAKE |-> rdf_count_reg != '0)
        else $error("wake popped an empty read queue");

    a_no_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_SW_POP |=> op != OP_SW_POP)
        else $error("two pops in one switch");

endmodule

FILE: rtl/thread_scheduler_wait_queues.sv
// Yield, exit, block read and sleep take longer when a switch happens than without
// one, and wake takes longer when the read queue holds a thread; create, timer tick
// and reap walk the slot table one slot per cycle.
// One command is in work at a time; the next item is taken the cycle after the result
// is loaded, and a result still held stalls that load.
// Reset (rst_n, asynchronous): all slots free but slot 0, which runs; both queues empty.
module thread_scheduler_wait_queues import tsq_pkg::*; #(
    parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
    parameter int AMOUNT_BITS  = AMOUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tsq_in_if.sink      in_ch,
    tsq_out_if.source   out_ch,
    tsq_cfg_if.sink     cfg
);

    // The controller sequences each command as a series of single memory
    // operations on the datapath; the datapath reports queue occupancy,
    // scan progress and whether the result register can take a new item.
    dp_op_t     op;
    dp_status_t status;
    logic       in_ready;

    // The re-arm period register can be written in any cycle.
    assign cfg.ready   = 1'b1;
    assign in_ch.ready = in_ready;

    tsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    // The slot status, slot amount and both FIFOs live in single-write
    // memories with registered reads; slot status entries that were never
    // written read as their reset value through a valid bit per slot.
    tsq_dp #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .AMOUNT_BITS  (AMOUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_item   (in_ch.payload),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.data),
        .status    (status),
        .out_item  (out_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready)
    );

endmodule
